// ===== rtl/rnelg_pkg.sv =====
// ----------------------------------------------------------------------------
// rnelg_pkg
// Shared types and constants for the ring neighbour exclusive LRU grant block.
// ----------------------------------------------------------------------------
package rnelg_pkg;

   localparam int MAX_SEATS_DEFAULT = 16;
   localparam int SEAT_W            = 6;
   localparam int TIME_W            = 32;
   localparam int COUNT_W           = 7;
   localparam logic [COUNT_W-1:0] SEAT_COUNT_RESET = 7'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_PICK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic scan_start;
      logic scan_step;
      logic pick;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic pass_last;
      logic emit_last;
   } status_type;

endpackage

// ===== rtl/rnelg_ram.sv =====
// ----------------------------------------------------------------------------
// rnelg_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rnelg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rnelg_ctrl.sv =====
// ----------------------------------------------------------------------------
// rnelg_ctrl
// Sequencer for load, selection passes, grant decisions and result emission.
// ----------------------------------------------------------------------------
module rnelg_ctrl
   import rnelg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       final_seat,
   input  status_type status,
   output logic       busy,
   output logic       rsp_strobe,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (final_seat) begin
                  cmd.clear      = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            cmd.pick = 1'b1;
            if (status.pass_last) begin
               state_in = ST_EMIT;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_EMIT: begin
            cmd.emit   = 1'b1;
            rsp_strobe = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/rnelg_dp.sv =====
// ----------------------------------------------------------------------------
// rnelg_dp
// Datapath: service time RAM, oldest-first selection scan, grant flags and
// result counter.
// ----------------------------------------------------------------------------
module rnelg_dp
   import rnelg_pkg::*;
#(
   parameter int MAX_SEATS = MAX_SEATS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic [SEAT_W-1:0]  req_seat,
   input  logic [TIME_W-1:0]  req_last_meal_time,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [SEAT_W-1:0]  rsp_grant_seat,
   output logic               rsp_granted,
   output logic               rsp_last_result
);

   localparam int AW = $clog2(MAX_SEATS);

   logic [COUNT_W-1:0]   seat_count_ff;
   logic [AW-1:0]        n_last_ff;
   logic [AW-1:0]        n_last_in;
   logic [AW-1:0]        scan_idx_ff;
   logic                 cmp_valid_ff;
   logic [AW-1:0]        cmp_idx_ff;
   logic                 best_found_ff;
   logic [TIME_W-1:0]    best_time_ff;
   logic [AW-1:0]        best_seat_ff;
   logic [AW-1:0]        pass_ff;
   logic [AW-1:0]        out_idx_ff;
   logic [MAX_SEATS-1:0] done_ff;
   logic [MAX_SEATS-1:0] grant_ff;
   logic [TIME_W-1:0]    rd_time;
   logic                 wr_ok;
   logic                 better;
   logic [AW-1:0]        up_seat;
   logic [AW-1:0]        down_seat;

   assign wr_ok = cmd.load && ({1'b0, req_seat} < COUNT_W'(MAX_SEATS));

   rnelg_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_SEATS)
   ) u_times (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (req_seat[AW-1:0]),
      .wr_data (req_last_meal_time),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_time)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seat_count_ff <= SEAT_COUNT_RESET;
      end else if (csr_wr_en) begin
         seat_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (seat_count_ff < COUNT_W'(2)) begin
         n_last_in = AW'(1);
      end else if (seat_count_ff > COUNT_W'(MAX_SEATS)) begin
         n_last_in = AW'(MAX_SEATS - 1);
      end else begin
         n_last_in = AW'(seat_count_ff - COUNT_W'(1));
      end
   end

   assign better = cmp_valid_ff && !done_ff[cmp_idx_ff] &&
                   (!best_found_ff || (rd_time < best_time_ff));

   assign up_seat   = (best_seat_ff == n_last_ff) ? '0 : best_seat_ff + AW'(1);
   assign down_seat = (best_seat_ff == '0) ? n_last_ff : best_seat_ff - AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         done_ff      <= '0;
         grant_ff     <= '0;
      end else begin
         cmp_valid_ff <= cmd.scan_step;
         if (cmd.clear) begin
            done_ff  <= '0;
            grant_ff <= '0;
         end else if (cmd.pick) begin
            done_ff[best_seat_ff] <= 1'b1;
            if (!grant_ff[up_seat] && !grant_ff[down_seat]) begin
               grant_ff[best_seat_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         n_last_ff  <= n_last_in;
         pass_ff    <= '0;
         out_idx_ff <= '0;
      end else begin
         if (cmd.pick) begin
            pass_ff <= pass_ff + AW'(1);
         end
         if (cmd.emit) begin
            out_idx_ff <= out_idx_ff + AW'(1);
         end
      end
      if (cmd.scan_start) begin
         scan_idx_ff   <= '0;
         best_found_ff <= 1'b0;
      end else begin
         if (cmd.scan_step) begin
            scan_idx_ff <= scan_idx_ff + AW'(1);
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_time_ff  <= rd_time;
            best_seat_ff  <= cmp_idx_ff;
         end
      end
      cmp_idx_ff <= scan_idx_ff;
   end

   assign status.scan_last = (scan_idx_ff == n_last_ff);
   assign status.pass_last = (pass_ff == n_last_ff);
   assign status.emit_last = (out_idx_ff == n_last_ff);

   assign rsp_grant_seat  = SEAT_W'(out_idx_ff);
   assign rsp_granted     = grant_ff[out_idx_ff];
   assign rsp_last_result = (out_idx_ff == n_last_ff);

endmodule

// ===== rtl/ring_neighbour_exclusive_lru_grant.sv =====
// ----------------------------------------------------------------------------
// ring_neighbour_exclusive_lru_grant
// Oldest-first arbiter for seats on a ring with neighbour exclusion.
// ----------------------------------------------------------------------------
// Each transaction on the req_ channel (start high while busy is low) loads
// the last service time of one seat below MAX_SEATS. A transaction with
// req_final_seat set also starts arbitration over the n seats in use (n is
// the csr_ seat count saturated to 2..MAX_SEATS). Arbitration runs n
// selection passes; each pass streams the n stored times out of the single
// read port of the time RAM, one per cycle, and picks the oldest seat not
// yet handled, granting it if neither ring neighbour holds a grant. Then n
// results are emitted on consecutive cycles, in seat order, each marked by
// rsp_strobe for one cycle. A final transaction keeps busy high until the
// last result is emitted; a plain load leaves busy low. The receiver cannot
// stall, so results always leave at one per cycle. Reset returns the
// controller to idle, clears the grant flags and sets the seat count to 5;
// stored service times are undefined until loaded.
// ----------------------------------------------------------------------------
module ring_neighbour_exclusive_lru_grant
   import rnelg_pkg::*;
#(
   parameter int MAX_SEATS = MAX_SEATS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data,
   input  logic               start,
   output logic               busy,
   input  logic [SEAT_W-1:0]  req_seat,
   input  logic [TIME_W-1:0]  req_last_meal_time,
   input  logic               req_final_seat,
   output logic               rsp_strobe,
   output logic [SEAT_W-1:0]  rsp_grant_seat,
   output logic               rsp_granted,
   output logic               rsp_last_result
);

   cmd_type    cmd;
   status_type status;

   rnelg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_seat (req_final_seat),
      .status     (status),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   rnelg_dp #(
      .MAX_SEATS (MAX_SEATS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_seat           (req_seat),
      .req_last_meal_time (req_last_meal_time),
      .cmd                (cmd),
      .status             (status),
      .rsp_grant_seat     (rsp_grant_seat),
      .rsp_granted        (rsp_granted),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for ring_neighbour_exclusive_lru_grant.
// ----------------------------------------------------------------------------
// Seat loads and arbitration requests are driven as command transactions with
// random gaps, none in quiet phases. Every accepted transaction for a seat in
// range updates a local copy of the stored service times. Every final one
// predicts the grant pattern: the seats are handled oldest first, lower seat
// on ties, and a seat is granted when neither ring neighbour holds a grant.
// Each strobed result is compared with the oldest prediction. The run covers
// several seat-count settings, including values that saturate at both ends.
// ----------------------------------------------------------------------------
module tb;
   import rnelg_pkg::*;

   localparam int SEATS      = MAX_SEATS_DEFAULT;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 34;

   typedef struct packed {
      logic [SEAT_W-1:0] seat;
      logic              granted;
      logic              last_flag;
   } grant_result_type;

   class grant_scoreboard_type;
      logic [TIME_W-1:0]  meal_time [SEATS];
      logic [COUNT_W-1:0] seat_count;
      grant_result_type   pending_grants [$];
      int errors;
      int requests;
      int arbitrations;
      int results;
      int grants_seen;
      int count_writes;

      function new();
         seat_count = SEAT_COUNT_RESET;
      endfunction

      function void write_seat_count(logic [COUNT_W-1:0] value);
         seat_count = value;
         count_writes++;
      endfunction

      function int active_seats();
         if (seat_count < 2) return 2;
         if (seat_count > SEATS) return SEATS;
         return int'(seat_count);
      endfunction

      function int pending();
         return pending_grants.size();
      endfunction

      function void note_request(logic [SEAT_W-1:0] seat, logic [TIME_W-1:0] stamp,
                                 logic is_last);
         int n;
         int oldest;
         int up;
         int down;
         bit handled [SEATS];
         bit granted [SEATS];
         grant_result_type res;
         requests++;
         if (seat < SEATS) meal_time[seat] = stamp;
         if (!is_last) return;
         arbitrations++;
         n = active_seats();
         for (int s = 0; s < SEATS; s++) begin
            handled[s] = 1'b0;
            granted[s] = 1'b0;
         end
         for (int pass = 0; pass < n; pass++) begin
            oldest = -1;
            for (int s = 0; s < n; s++) begin
               if (!handled[s] && (oldest < 0 || meal_time[s] < meal_time[oldest]))
                  oldest = s;
            end
            handled[oldest] = 1'b1;
            up = (oldest + 1) % n;
            down = (oldest + n - 1) % n;
            if (!granted[up] && !granted[down]) granted[oldest] = 1'b1;
         end
         for (int s = 0; s < n; s++) begin
            res.seat = SEAT_W'(s);
            res.granted = granted[s];
            res.last_flag = (s == n - 1);
            pending_grants.push_back(res);
         end
      endfunction

      function void check_result(logic [SEAT_W-1:0] seat, logic granted, logic last_flag);
         grant_result_type exp;
         if (pending_grants.size() == 0) begin
            $error("unexpected grant result for seat %0d", seat);
            errors++;
            return;
         end
         exp = pending_grants.pop_front();
         results++;
         if (granted === 1'b1) grants_seen++;
         if (seat !== exp.seat) begin
            $error("grant_seat: expected %0d, got %0d", exp.seat, seat);
            errors++;
         end
         if (granted !== exp.granted) begin
            $error("granted: expected %0d, got %0d", exp.granted, granted);
            errors++;
         end
         if (last_flag !== exp.last_flag) begin
            $error("last_result: expected %0d, got %0d", exp.last_flag, last_flag);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic               start = 1'b0;
   logic               busy;
   logic [SEAT_W-1:0]  req_seat = '0;
   logic [TIME_W-1:0]  req_last_meal_time = '0;
   logic               req_final_seat = 1'b0;
   logic               rsp_strobe;
   logic [SEAT_W-1:0]  rsp_grant_seat;
   logic               rsp_granted;
   logic               rsp_last_result;

   grant_scoreboard_type sb;
   int                   idle_cycles = 0;
   int                   items_sent = 0;
   bit                   no_idle = 1'b0;
   logic [SEATS-1:0]     stored_mask = '0;

   ring_neighbour_exclusive_lru_grant u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .start              (start),
      .busy               (busy),
      .req_seat           (req_seat),
      .req_last_meal_time (req_last_meal_time),
      .req_final_seat     (req_final_seat),
      .rsp_strobe         (rsp_strobe),
      .rsp_grant_seat     (rsp_grant_seat),
      .rsp_granted        (rsp_granted),
      .rsp_last_result    (rsp_last_result)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_wr_en === 1'b1) begin
            sb.write_seat_count(csr_wr_data);
            moved = 1'b1;
         end
         if (start === 1'b1 && busy === 1'b0) begin
            sb.note_request(req_seat, req_last_meal_time, req_final_seat);
            moved = 1'b1;
         end
         if (rsp_strobe !== 1'b0) begin
            sb.check_result(rsp_grant_seat, rsp_granted, rsp_last_result);
            moved = 1'b1;
         end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [TIME_W-1:0] pick_meal_time(int mode);
      case (mode)
         0: return $urandom_range(0, 3);
         1: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return '1;
               default: return 32'hFFFF_FFFE;
            endcase
         end
         2: return 32'h8000_0000 + $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(int seat, logic [TIME_W-1:0] stamp, bit is_last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_seat <= SEAT_W'(seat);
      req_last_meal_time <= stamp;
      req_final_seat <= is_last;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if (seat < SEATS) stored_mask[seat] = 1'b1;
      if (seat < SEATS || is_last) items_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0 || busy !== 1'b0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(int value);
      csr_wr_data <= COUNT_W'(value);
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_ring();
      int n;
      int rot;
      int mode;
      n = sb.active_seats();
      rot = $urandom_range(0, n - 1);
      mode = $urandom_range(0, 3);
      for (int k = 0; k < n; k++)
         send_item((k + rot) % n, pick_meal_time(mode), k == n - 1);
   endtask

   task automatic load_stray();
      int seat;
      int need;
      bit is_last;
      logic [SEATS-1:0] after;
      seat = $urandom_range(0, 63);
      is_last = ($urandom_range(0, 3) == 0);
      need = (1 << sb.active_seats()) - 1;
      after = stored_mask;
      if (seat < SEATS) after[seat] = 1'b1;
      if ((int'(after) & need) != need) is_last = 1'b0;
      send_item(seat, pick_meal_time($urandom_range(0, 3)), is_last);
   endtask

   task automatic load_partial();
      int len;
      len = $urandom_range(1, sb.active_seats() - 1);
      for (int k = 0; k < len; k++)
         send_item(k, pick_meal_time($urandom_range(0, 3)), 1'b0);
   endtask

   task automatic run_phase(int count, bit quiet);
      int target;
      int pick;
      settle();
      write_count(count);
      no_idle = quiet;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) load_ring();
         else if (pick < 8) load_stray();
         else load_partial();
      end
   endtask

   initial begin
      int counts [10];
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Five seats after reset, with ties and both extreme times.
      send_item(0, 32'h0, 1'b0);
      send_item(1, 32'hFFFF_FFFF, 1'b0);
      send_item(2, 32'h0, 1'b0);
      send_item(3, 32'd7, 1'b0);
      send_item(4, 32'd7, 1'b1);
      send_item(63, 32'h0, 1'b1);
      send_item(40, 32'd1234, 1'b0);
      send_item(9, 32'd1, 1'b0);
      send_item(3, 32'd2, 1'b1);

      // Two-seat ring: tie first, then the upper seat is older.
      settle();
      write_count(2);
      send_item(0, 32'd5, 1'b0);
      send_item(1, 32'd5, 1'b1);
      send_item(0, 32'd9, 1'b1);
      settle();
      write_count(0);
      send_item(1, 32'hFFFF_FFFF, 1'b1);
      settle();
      write_count(1);
      send_item(42, 32'h0, 1'b1);

      counts = '{16, 127, 3, 64, 2, 6, 0, 17,
                 $urandom_range(0, 127), $urandom_range(2, 16)};
      for (int p = 0; p < 10; p++)
         run_phase(counts[p], (p % 3) == 1);

      start <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (40) @(posedge clock);

      $display("Ran %0d request transactions, %0d of them arbitrations, over %0d seat counts.",
               sb.requests, sb.arbitrations, sb.count_writes + 1);
      $display("Checked %0d grant results, %0d of them granted.", sb.results, sb.grants_seen);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rnelg_pkg.sv
rtl/rnelg_ram.sv
rtl/rnelg_ctrl.sv
rtl/rnelg_dp.sv
rtl/ring_neighbour_exclusive_lru_grant.sv
verif/tb.sv
